// ===== design/wdhc_pkg.sv =====
// ----------------------------------------------------------------------------
// wdhc_pkg
// Shared types, widths, constants and the arctangent table of the waypoint
// heading drive controller.
// ----------------------------------------------------------------------------
package wdhc_pkg;

    localparam int COORD_BITS   = 10;
    localparam int CORDIC_STEPS = 14;
    localparam int TABLE_LEN    = 24;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int CX_W         = DIFF_W + 8 + 3;
    localparam int Z_W          = 26;
    localparam int ANG_W        = 13;
    localparam int ERR_W        = 15;
    localparam int PWM_W        = 13;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int CFG_W        = 10;

    localparam logic [PWM_W-1:0] PWM_MAX    = 13'd5000;
    localparam logic [PWM_W-1:0] TURN_BASE  = 13'd1500;
    localparam logic [PWM_W-1:0] DRIVE_BASE = 13'd2800;
    localparam logic signed [ERR_W-1:0] HALF_TURN_Q4 = 15'sd2880;
    localparam logic signed [ERR_W-1:0] FULL_TURN_Q4 = 15'sd5760;

    // register indexes
    localparam logic [2:0] CFG_GOAL_A_X  = 3'd0;
    localparam logic [2:0] CFG_GOAL_B_X  = 3'd1;
    localparam logic [2:0] CFG_TARGET0_X = 3'd2;
    localparam logic [2:0] CFG_TARGET0_Y = 3'd3;
    localparam logic [2:0] CFG_TARGET1_X = 3'd4;
    localparam logic [2:0] CFG_TARGET1_Y = 3'd5;
    localparam logic [2:0] CFG_ANGLE_THR = 3'd6;
    localparam logic [2:0] CFG_DIST_THR  = 3'd7;

    // navigation phases
    localparam logic [1:0] NAV_TURN  = 2'd0;
    localparam logic [1:0] NAV_DRIVE = 2'd1;
    localparam logic [1:0] NAV_ALIGN = 2'd2;
    localparam logic [1:0] NAV_SWAP  = 2'd3;

    localparam logic [2:0] PH_START = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_T,
        ST_CORDIC,
        ST_APPLY,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    side;
    } t_hdiff;

    // arctangent of 2^-i in Q.16 degrees
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117305;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/wdhc_cordic.sv =====
// ----------------------------------------------------------------------------
// wdhc_cordic
// Iterative vectoring CORDIC: bearing atan2(ay, ax) in Q.4 degrees, one
// micro-rotation per cycle through a single add/shift unit.
// ----------------------------------------------------------------------------
module wdhc_cordic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [wdhc_pkg::DIFF_W-1:0]   i_ay,
    input  logic signed [wdhc_pkg::DIFF_W-1:0]   i_ax,
    output logic                                 o_done,
    output logic signed [wdhc_pkg::ANG_W-1:0]    o_bearing
);
    import wdhc_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic                    r_zero;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [CX_W-1:0]  r_x;
    logic signed [CX_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;

    logic signed [CX_W-1:0]  w_x0;
    logic signed [CX_W-1:0]  w_y0;
    logic signed [CX_W-1:0]  w_sx;
    logic signed [CX_W-1:0]  w_sy;
    logic signed [Z_W-1:0]   w_atan;
    logic signed [Z_W-1:0]   w_zr;
    logic signed [Z_W-1:0]   w_q;

    // scale the vector by 256
    assign w_x0 = {{3{i_ax[DIFF_W-1]}}, i_ax, 8'b0};
    assign w_y0 = {{3{i_ay[DIFF_W-1]}}, i_ay, 8'b0};

    assign w_sx   = r_x >>> r_cnt;
    assign w_sy   = r_y >>> r_cnt;
    assign w_atan = atan_q16(5'(r_cnt));

    // control: run the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // datapath: pre-rotate into the right half plane, then rotate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_ax == '0) && (i_ay == '0);
            if (i_ax < 0) begin
                if (i_ay >= 0) begin
                    r_x <= w_y0;
                    r_y <= -w_x0;
                    r_z <= 26'sd5898240;
                end else begin
                    r_x <= -w_y0;
                    r_y <= w_x0;
                    r_z <= -26'sd5898240;
                end
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_atan;
            end
        end
    end

    // round half up to Q.4 and clamp to a half turn
    assign w_zr = r_z + 26'sd2048;
    assign w_q  = w_zr >>> 12;

    always_comb begin
        if (r_zero) begin
            o_bearing = '0;
        end else if (w_q > 26'sd2880) begin
            o_bearing = 13'sd2880;
        end else if (w_q < -26'sd2880) begin
            o_bearing = -13'sd2880;
        end else begin
            o_bearing = w_q[ANG_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

// ===== design/waypoint_heading_drive_controller.sv =====
// ----------------------------------------------------------------------------
// waypoint_heading_drive_controller
// Per control tick: bearing to the goal, heading error, and a four-phase
// turn / drive / align / swap sequencer driving two saturated PWM values.
// ----------------------------------------------------------------------------
// One tick is taken at a time. The first tick after reset only picks the goal,
// and its result passes from the write state into the output register. Every
// later tick squares dx, dy and the distance threshold in turn on one shared
// multiplier, runs the iterative CORDIC until its done flag, then passes an
// apply and a write state before the result sits in the output register. The
// input is stalled while a tick is in work; a finished result waits in the
// output register, and the next tick is taken meanwhile.
module waypoint_heading_drive_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [2:0]                           i_cfg_index,
    input  logic [wdhc_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [wdhc_pkg::COORD_BITS-1:0] i_robot_x,
    input  logic signed [wdhc_pkg::COORD_BITS-1:0] i_robot_y,
    input  logic signed [8:0]                    i_heading,
    input  logic                                 i_team_side,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [wdhc_pkg::PWM_W-1:0]           o_left_pwm,
    output logic [wdhc_pkg::PWM_W-1:0]           o_right_pwm,
    output logic                                 o_left_dir,
    output logic                                 o_right_dir,
    output logic                                 o_indicator,
    output logic [2:0]                           o_phase,
    output logic signed [13:0]                   o_heading_error,
    output logic                                 o_turn_side
);
    import wdhc_pkg::*;

    // configuration
    logic signed [COORD_BITS-1:0] r_goal_a_x, r_goal_b_x;
    logic signed [COORD_BITS-1:0] r_t0_x, r_t0_y, r_t1_x, r_t1_y;
    logic [7:0]                   r_ang_thr, r_dist_thr;

    // navigation state
    t_state                       r_state, n_state;
    logic                         r_started;
    logic [1:0]                   r_nav;
    logic                         r_tidx;
    logic signed [COORD_BITS-1:0] r_goal_x, r_goal_y;
    logic [PWM_W-1:0]             r_pwm_l, r_pwm_r;
    logic [1:0]                   r_dir;
    logic                         r_led;

    // tick work registers
    logic signed [DIFF_W-1:0]     r_dx, r_dy;
    logic signed [ANG_W-1:0]      r_hq;
    logic [SQ_W-1:0]              r_d2;
    logic [SQ_W-1:0]              r_thr2;
    logic [2:0]                   r_pend_phase;
    logic signed [ERR_W-1:0]      r_pend_err;
    logic                         r_pend_side;
    logic                         r_out_valid;

    logic                         w_accept;
    logic                         w_load_out;
    logic                         w_cordic_start;
    logic                         w_cordic_done;
    logic signed [ANG_W-1:0]      w_bearing;
    logic signed [8:0]            w_hsat;
    logic signed [DIFF_W-1:0]     w_ma, w_mb;
    logic signed [SQ_W-1:0]       w_prod;
    t_hdiff                       w_hd_goal, w_hd_zero, w_hd;
    logic                         w_reached;
    logic [PWM_W-1:0]             w_turn_p, w_curve_p;
    logic [ERR_W-1:0]             w_ath, w_ath2;
    logic [ERR_W+3:0]             w_err10;
    logic [ERR_W-1:0]             w_turn_raw, w_curve_raw;

    function automatic t_hdiff heading_diff(input logic signed [ERR_W-1:0] t,
                                            input logic signed [ERR_W-1:0] h);
        t_hdiff                  d;
        logic signed [ERR_W-1:0] aux;
        logic                    wrapped;
        aux     = t - HALF_TURN_Q4;
        wrapped = aux < -HALF_TURN_Q4;
        if (wrapped) begin
            aux = aux + FULL_TURN_Q4;
        end
        if (!wrapped) begin
            if (aux <= h && h <= t) begin
                d.err  = t - h;
                d.side = 1'b0;
            end else begin
                d.err  = ((h < 0) ? h + FULL_TURN_Q4 : h) - t;
                d.side = 1'b1;
            end
        end else begin
            if (h > t && h < aux) begin
                d.err  = h - t;
                d.side = 1'b1;
            end else begin
                d.err  = (h < 0) ? t - h : t + FULL_TURN_Q4 - h;
                d.side = 1'b0;
            end
        end
        return d;
    endfunction

    wdhc_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cordic_start),
        .i_ay      (-r_dx),
        .i_ax      (r_dy),
        .o_done    (w_cordic_done),
        .o_bearing (w_bearing)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load_out = (r_state == ST_WRITE) && (!r_out_valid || !i_out_stall);

    // saturate the heading to a half turn
    assign w_hsat = (i_heading > 9'sd180) ? 9'sd180 :
                    (i_heading < -9'sd180) ? -9'sd180 : i_heading;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_a_x <= -10'sd100;
            r_goal_b_x <= 10'sd115;
            r_t0_x     <= 10'sd0;
            r_t0_y     <= 10'sd0;
            r_t1_x     <= 10'sd80;
            r_t1_y     <= 10'sd30;
            r_ang_thr  <= 8'd15;
            r_dist_thr <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GOAL_A_X:  r_goal_a_x <= i_cfg_data;
                CFG_GOAL_B_X:  r_goal_b_x <= i_cfg_data;
                CFG_TARGET0_X: r_t0_x     <= i_cfg_data;
                CFG_TARGET0_Y: r_t0_y     <= i_cfg_data;
                CFG_TARGET1_X: r_t1_x     <= i_cfg_data;
                CFG_TARGET1_Y: r_t1_y     <= i_cfg_data;
                CFG_ANGLE_THR: r_ang_thr  <= i_cfg_data[7:0];
                CFG_DIST_THR:  r_dist_thr <= i_cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_accept) n_state = r_started ? ST_SQ_X : ST_WRITE;
            ST_SQ_X:   n_state = ST_SQ_Y;
            ST_SQ_Y:   n_state = ST_SQ_T;
            ST_SQ_T:   n_state = ST_CORDIC;
            ST_CORDIC: if (w_cordic_done) n_state = ST_APPLY;
            ST_APPLY:  n_state = ST_WRITE;
            ST_WRITE:  if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall     = 1'b1;
        w_cordic_start = 1'b0;
        w_ma           = r_dx;
        w_mb           = r_dx;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_SQ_X: begin
                w_ma = r_dx;
                w_mb = r_dx;
            end
            ST_SQ_Y: begin
                w_ma = r_dy;
                w_mb = r_dy;
            end
            ST_SQ_T: begin
                w_ma           = DIFF_W'($signed({1'b0, r_dist_thr}));
                w_mb           = DIFF_W'($signed({1'b0, r_dist_thr}));
                w_cordic_start = 1'b1;
            end
            default: ;
        endcase
    end

    // shared multiplier
    assign w_prod = w_ma * w_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // heading error and drive values
    assign w_hd_goal = heading_diff(ERR_W'(w_bearing), ERR_W'(r_hq));
    assign w_hd_zero = heading_diff('0, ERR_W'(r_hq));
    assign w_hd      = (r_nav == NAV_ALIGN) ? w_hd_zero : w_hd_goal;
    assign w_reached = r_d2 < r_thr2;
    assign w_ath     = ERR_W'({r_ang_thr, 4'b0});
    assign w_ath2    = ERR_W'({r_ang_thr, 5'b0});

    assign w_turn_raw  = ERR_W'(TURN_BASE) + (w_hd.err >>> 1);
    assign w_err10     = ({4'b0, w_hd.err} << 3) + ({4'b0, w_hd.err} << 1);
    assign w_curve_raw = ERR_W'(DRIVE_BASE) + w_err10[ERR_W+3:4];
    assign w_turn_p    = (w_turn_raw > ERR_W'(PWM_MAX)) ? PWM_MAX : w_turn_raw[PWM_W-1:0];
    assign w_curve_p   = (w_curve_raw > ERR_W'(PWM_MAX)) ? PWM_MAX : w_curve_raw[PWM_W-1:0];

    // navigation state and tick work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_nav     <= NAV_TURN;
            r_tidx    <= 1'b0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_pwm_l   <= '0;
            r_pwm_r   <= '0;
            r_dir     <= 2'b11;
            r_led     <= 1'b0;
        end else begin
            if (w_accept && !r_started) begin
                r_goal_x  <= i_team_side ? r_goal_a_x : r_goal_b_x;
                r_goal_y  <= '0;
                r_nav     <= NAV_TURN;
                r_started <= 1'b1;
            end
            if (r_state == ST_APPLY) begin
                case (r_nav)
                    NAV_TURN: begin
                        if (w_reached) begin
                            r_nav <= NAV_ALIGN;
                        end else if (w_hd.err < $signed(w_ath)) begin
                            r_nav <= NAV_DRIVE;
                        end else begin
                            r_pwm_l <= w_turn_p;
                            r_pwm_r <= w_turn_p;
                            r_dir   <= w_hd.side ? 2'b01 : 2'b10;
                        end
                    end
                    NAV_DRIVE: begin
                        if (w_reached) begin
                            r_nav <= NAV_ALIGN;
                            r_led <= 1'b1;
                        end else if (w_hd.err > $signed(w_ath2)) begin
                            r_nav <= NAV_TURN;
                            r_led <= 1'b1;
                        end else begin
                            r_led   <= 1'b0;
                            r_pwm_l <= w_hd.side ? w_curve_p : DRIVE_BASE;
                            r_pwm_r <= w_hd.side ? DRIVE_BASE : w_curve_p;
                            r_dir   <= 2'b00;
                        end
                    end
                    NAV_ALIGN: begin
                        if (w_hd.err < $signed(w_ath)) begin
                            r_nav <= NAV_SWAP;
                        end else begin
                            r_pwm_l <= w_turn_p;
                            r_pwm_r <= w_turn_p;
                            r_dir   <= w_hd.side ? 2'b01 : 2'b10;
                        end
                    end
                    default: begin
                        r_pwm_l  <= '0;
                        r_pwm_r  <= '0;
                        r_tidx   <= ~r_tidx;
                        r_goal_x <= r_tidx ? r_t0_x : r_t1_x;
                        r_goal_y <= r_tidx ? r_t0_y : r_t1_y;
                        r_nav    <= NAV_TURN;
                    end
                endcase
            end
        end
    end

    // capture the tick, accumulate squares, hold pending result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dx         <= DIFF_W'(r_goal_x) - DIFF_W'(i_robot_x);
            r_dy         <= DIFF_W'(r_goal_y) - DIFF_W'(i_robot_y);
            r_hq         <= ANG_W'({w_hsat, 4'b0});
            r_pend_phase <= PH_START;
            r_pend_err   <= '0;
            r_pend_side  <= 1'b0;
        end
        case (r_state)
            ST_SQ_X: r_d2   <= SQ_W'(w_prod);
            ST_SQ_Y: r_d2   <= r_d2 + SQ_W'(w_prod);
            ST_SQ_T: r_thr2 <= SQ_W'(w_prod);
            ST_APPLY: begin
                r_pend_phase <= {1'b0, r_nav} + 3'd1;
                r_pend_err   <= w_hd.err;
                r_pend_side  <= w_hd.side;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_left_pwm      <= r_pwm_l;
            o_right_pwm     <= r_pwm_r;
            o_left_dir      <= r_dir[0];
            o_right_dir     <= r_dir[1];
            o_indicator     <= r_led;
            o_phase         <= r_pend_phase;
            o_heading_error <= r_pend_err[13:0];
            o_turn_side     <= r_pend_side;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_pwm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pwm_l <= PWM_MAX) && (r_pwm_r <= PWM_MAX))
        else $error("pwm register above limit");

    a_done_in_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == ST_CORDIC))
        else $error("cordic done outside its state");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (r_pend_phase <= 3'd4))
        else $error("phase code out of range");
`endif

endmodule

// ===== dv/waypoint_heading_drive_controller_checker.sv =====
// ----------------------------------------------------------------------------
// waypoint_heading_drive_controller_checker
// Watches the tick and result channels and the register port, predicts each
// result of the controller from its own copy of state and registers, and
// compares results field by field in order.
// ----------------------------------------------------------------------------
module waypoint_heading_drive_controller_checker
    import wdhc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_index,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [COORD_BITS-1:0]  i_robot_x,
    input  logic signed [COORD_BITS-1:0]  i_robot_y,
    input  logic signed [8:0]             i_heading,
    input  logic                          i_team_side,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [PWM_W-1:0]              i_left_pwm,
    input  logic [PWM_W-1:0]              i_right_pwm,
    input  logic                          i_left_dir,
    input  logic                          i_right_dir,
    input  logic                          i_indicator,
    input  logic [2:0]                    i_phase,
    input  logic signed [13:0]            i_heading_error,
    input  logic                          i_turn_side,
    output int                            o_mismatches,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PWM_W-1:0]   lpwm;
        logic [PWM_W-1:0]   rpwm;
        logic               ldir;
        logic               rdir;
        logic               led;
        logic [2:0]         phase;
        logic signed [13:0] err;
        logic               side;
    } t_drive_result;

    // arctangent of 2^-i, Q.16 degrees
    localparam longint ATAN_Q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    // register copy
    logic signed [9:0] goal_a_x, goal_b_x, tgt0_x, tgt0_y, tgt1_x, tgt1_y;
    logic [7:0]        angle_thr, dist_thr;

    // controller state copy
    bit          started;
    logic [1:0]  nav;
    bit          tgt_sel;
    longint      goal_x, goal_y;
    longint      pwm_l, pwm_r;
    logic [1:0]  dir_pins;
    bit          led;

    t_drive_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic longint bearing_q4(longint ay, longint ax);
        longint x, y, z, t, nx, ny, r;
        x = ax * 256;
        y = ay * 256;
        z = 0;
        if (x == 0 && y == 0) return 0;
        // fold left half plane into the right
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q16[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q16[i];
            end
            x = nx;
            y = ny;
        end
        r = (z + 2048) >>> 12;
        if (r > 2880) r = 2880;
        if (r < -2880) r = -2880;
        return r;
    endfunction

    function automatic void heading_gap(input longint t, input longint h,
                                        output longint err, output bit side);
        longint aux;
        aux = t - 2880;
        if (aux < -2880) begin
            aux += 5760;
            if (h > t && h < aux) begin
                err = h - t; side = 1;
            end else begin
                err = (h < 0) ? t - h : t + 5760 - h; side = 0;
            end
        end else if (aux <= h && h <= t) begin
            err = t - h; side = 0;
        end else begin
            err = (h < 0 ? h + 5760 : h) - t; side = 1;
        end
    endfunction

    function automatic longint clip_pwm(longint v);
        if (v < 0) return 0;
        if (v > 5000) return 5000;
        return v;
    endfunction

    function automatic void spin_in_place(longint err, bit side);
        pwm_l = clip_pwm(1500 + err / 2);
        pwm_r = pwm_l;
        dir_pins = side ? 2'b01 : 2'b10;
    endfunction

    function automatic void curve_drive(longint err, bit side);
        longint p;
        p = clip_pwm(2800 + (err * 10) / 16);
        if (side) begin
            pwm_l = p; pwm_r = 2800;
        end else begin
            pwm_l = 2800; pwm_r = p;
        end
        dir_pins = 2'b00;
    endfunction

    function automatic t_drive_result next_drive(longint x, longint y, longint hd,
                                                 bit team);
        longint h, ath, dth, err, dx, dy;
        bit side, reached;
        logic [2:0] shown;
        t_drive_result res;
        h = hd;
        err = 0;
        side = 0;
        if (h > 180) h = 180;
        if (h < -180) h = -180;
        h *= 16;
        ath = longint'(angle_thr) * 16;
        dth = longint'(dist_thr);
        if (!started) begin
            // first tick: pick the goal by team pin
            goal_x = team ? longint'(goal_a_x) : longint'(goal_b_x);
            goal_y = 0;
            nav = NAV_TURN;
            started = 1;
            shown = PH_START;
        end else begin
            dx = goal_x - x;
            dy = goal_y - y;
            heading_gap(bearing_q4(-dx, dy), h, err, side);
            reached = (dx * dx + dy * dy) < dth * dth;
            shown = {1'b0, nav} + 3'd1;
            case (nav)
                NAV_TURN: begin
                    if (reached) nav = NAV_ALIGN;
                    else if (err < ath) nav = NAV_DRIVE;
                    else spin_in_place(err, side);
                end
                NAV_DRIVE: begin
                    if (reached) begin
                        nav = NAV_ALIGN; led = 1;
                    end else if (err > 2 * ath) begin
                        nav = NAV_TURN; led = 1;
                    end else begin
                        led = 0; curve_drive(err, side);
                    end
                end
                NAV_ALIGN: begin
                    heading_gap(0, h, err, side);
                    if (err < ath) nav = NAV_SWAP;
                    else spin_in_place(err, side);
                end
                default: begin
                    // swap: stop and head for the other target
                    pwm_l = 0;
                    pwm_r = 0;
                    tgt_sel ^= 1;
                    goal_x = tgt_sel ? longint'(tgt1_x) : longint'(tgt0_x);
                    goal_y = tgt_sel ? longint'(tgt1_y) : longint'(tgt0_y);
                    nav = NAV_TURN;
                end
            endcase
        end
        res.lpwm  = pwm_l[PWM_W-1:0];
        res.rpwm  = pwm_r[PWM_W-1:0];
        res.ldir  = dir_pins[0];
        res.rdir  = dir_pins[1];
        res.led   = led;
        res.phase = shown;
        res.err   = err[13:0];
        res.side  = side;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_drive_result got, want;
        if (!i_rst_n) begin
            goal_a_x  <= -10'sd100;
            goal_b_x  <= 10'sd115;
            tgt0_x    <= '0;
            tgt0_y    <= '0;
            tgt1_x    <= 10'sd80;
            tgt1_y    <= 10'sd30;
            angle_thr <= 8'd15;
            dist_thr  <= 8'd5;
            started   = 0;
            nav       = NAV_TURN;
            tgt_sel   = 0;
            goal_x    = 0;
            goal_y    = 0;
            pwm_l     = 0;
            pwm_r     = 0;
            dir_pins  = 2'b11;
            led       = 0;
            expected_results.delete();
            o_mismatches = 0;
        end else begin
            // compare a result transfer with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got = '{i_left_pwm, i_right_pwm, i_left_dir, i_right_dir,
                        i_indicator, i_phase, i_heading_error, i_turn_side};
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("%0t: result with none expected: %p", $realtime, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
            // predict a tick transfer
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(next_drive(longint'(i_robot_x),
                    longint'(i_robot_y), longint'(i_heading), i_team_side));
            // track register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GOAL_A_X:  goal_a_x  <= i_cfg_data;
                    CFG_GOAL_B_X:  goal_b_x  <= i_cfg_data;
                    CFG_TARGET0_X: tgt0_x    <= i_cfg_data;
                    CFG_TARGET0_Y: tgt0_y    <= i_cfg_data;
                    CFG_TARGET1_X: tgt1_x    <= i_cfg_data;
                    CFG_TARGET1_Y: tgt1_y    <= i_cfg_data;
                    CFG_ANGLE_THR: angle_thr <= i_cfg_data[7:0];
                    CFG_DIST_THR:  dist_thr  <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/waypoint_heading_drive_controller_tb.sv =====
// ----------------------------------------------------------------------------
// waypoint_heading_drive_controller_tb
// Drives control ticks and register settings into the controller with random
// gaps between ticks and random result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module waypoint_heading_drive_controller_tb;
    import wdhc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic                          clk = 0;
    logic                          rst_n = 0;
    logic                          cfg_we = 0;
    logic [2:0]                    cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 0;
    logic                          in_stall;
    logic signed [COORD_BITS-1:0]  robot_x = '0;
    logic signed [COORD_BITS-1:0]  robot_y = '0;
    logic signed [8:0]             heading = '0;
    logic                          team_side = 0;
    logic                          out_valid;
    logic                          out_stall = 0;
    logic [PWM_W-1:0]              left_pwm, right_pwm;
    logic                          left_dir, right_dir, indicator, turn_side;
    logic [2:0]                    phase;
    logic signed [13:0]            heading_error;
    int                            mismatches, pending;
    int                            cycles = 0;
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;

    // goals and targets as last written, used to aim the ticks
    logic signed [9:0] anchor_x [4];
    logic signed [9:0] anchor_y [4];

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    waypoint_heading_drive_controller u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_robot_x(robot_x), .i_robot_y(robot_y), .i_heading(heading),
        .i_team_side(team_side),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_left_pwm(left_pwm), .o_right_pwm(right_pwm),
        .o_left_dir(left_dir), .o_right_dir(right_dir),
        .o_indicator(indicator), .o_phase(phase),
        .o_heading_error(heading_error), .o_turn_side(turn_side)
    );

    waypoint_heading_drive_controller_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_robot_x(robot_x), .i_robot_y(robot_y), .i_heading(heading),
        .i_team_side(team_side),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_left_pwm(left_pwm), .i_right_pwm(right_pwm),
        .i_left_dir(left_dir), .i_right_dir(right_dir),
        .i_indicator(indicator), .i_phase(phase),
        .i_heading_error(heading_error), .i_turn_side(turn_side),
        .o_mismatches(mismatches), .o_pending(pending)
    );

    // random result stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // hard stop on a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("waypoint_heading_drive_controller verification failed");
            $finish;
        end
    end

    // one tick transfer; valid stays high into the next tick unless idling
    task automatic send_tick(input logic [9:0] x, input logic [9:0] y,
                             input logic [8:0] h, input logic team);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        robot_x   <= x;
        robot_y   <= y;
        heading   <= h;
        team_side <= team;
        in_valid  <= 1;
        // stall seen at a falling edge holds through the next rising edge
        while (in_stall) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 0;
    endtask

    task automatic load_settings(input logic [9:0] ga, input logic [9:0] gb,
                                 input logic [9:0] t0x, input logic [9:0] t0y,
                                 input logic [9:0] t1x, input logic [9:0] t1y,
                                 input logic [7:0] ath, input logic [7:0] dth);
        write_reg(CFG_GOAL_A_X, ga);
        write_reg(CFG_GOAL_B_X, gb);
        write_reg(CFG_TARGET0_X, t0x);
        write_reg(CFG_TARGET0_Y, t0y);
        write_reg(CFG_TARGET1_X, t1x);
        write_reg(CFG_TARGET1_Y, t1y);
        write_reg(CFG_ANGLE_THR, {2'b00, ath});
        write_reg(CFG_DIST_THR, {2'b00, dth});
        anchor_x = '{ga, gb, t0x, t1x};
        anchor_y = '{10'sd0, 10'sd0, t0y, t1y};
    endtask

    // mostly ticks near a goal or target, headings near zero, in range or random
    task automatic random_tick();
        int k;
        logic [9:0] x, y;
        logic [8:0] h;
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 99) < 60) begin
            x = anchor_x[k] + 10'($urandom_range(0, 12)) - 10'd6;
            y = anchor_y[k] + 10'($urandom_range(0, 12)) - 10'd6;
        end else begin
            x = 10'($urandom);
            y = 10'($urandom);
        end
        case ($urandom_range(0, 2))
            0: h = 9'($urandom_range(0, 40)) - 9'd20;
            1: h = 9'($urandom_range(0, 360)) - 9'd180;
            default: h = 9'($urandom);
        endcase
        send_tick(x, y, h, 1'($urandom));
    endtask

    initial begin
        anchor_x = '{-10'sd100, 10'sd115, 10'sd0, 10'sd80};
        anchor_y = '{10'sd0, 10'sd0, 10'sd0, 10'sd30};
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: reset settings, first tick picks goal b
        send_tick(10'sd0, 10'sd0, 9'sd0, 1'b0);
        send_tick(10'sd115, 10'sd0, 9'sd0, 1'b1);       // robot on goal
        send_tick(-10'sd512, -10'sd512, -9'sd256, 1'b0); // below heading range
        send_tick(10'sd511, 10'sd511, 9'sd255, 1'b1);    // above heading range
        send_tick(-10'sd512, 10'sd511, 9'sd180, 1'b0);
        send_tick(10'sd511, -10'sd512, -9'sd180, 1'b1);
        send_tick(10'sd114, 10'sd1, 9'sd90, 1'b0);
        send_tick(10'sd115, 10'sd2, 9'sd0, 1'b0);
        send_tick(10'sd0, 10'sd0, 9'sd0, 1'b0);
        send_tick(10'sd80, 10'sd30, -9'sd90, 1'b1);
        send_tick(10'sd80, 10'sd30, 9'sd0, 1'b1);
        send_tick(10'sd80, 10'sd30, 9'sd0, 1'b1);
        send_tick(10'sd0, 10'sd0, 9'sd0, 1'b0);
        drain();

        // wide thresholds make every phase easy to reach
        load_settings(-10'sd512, 10'sd511, -10'sd512, 10'sd511, 10'sd511,
                      -10'sd512, 8'd180, 8'd255);
        send_idle_pct = 10;
        recv_idle_pct = 58;
        repeat (70) random_tick();
        drain();

        load_settings(10'sd511, -10'sd512, 10'sd10, -10'sd20, -10'sd40,
                      10'sd60, 8'd0, 8'd0);
        repeat (60) random_tick();
        drain();

        load_settings(10'sd3, -10'sd7, 10'sd100, 10'sd100, -10'sd100,
                      -10'sd100, 8'd30, 8'd20);
        send_idle_pct = 58;
        recv_idle_pct = 10;
        repeat (135) random_tick();
        drain();

        load_settings(-10'sd200, 10'sd200, 10'sd0, 10'sd0, 10'sd255,
                      10'sd255, 8'd90, 8'd128);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (135) random_tick();
        drain();

        if (mismatches == 0)
            $display("waypoint_heading_drive_controller verification clean");
        else
            $display("waypoint_heading_drive_controller verification failed");
        $finish;
    end

endmodule
